/* sv/dsm_pkg.sv */
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared constants for the delta symbol mapper: table geometry, field widths
// and the register map of the configuration port.
// ----------------------------------------------------------------------------
package dsm_pkg;

  localparam int unsigned QUOTIENT_BOUND  = 50;
  localparam int unsigned REMAINDER_BOUND = 31;
  localparam int unsigned QUANT_STEP      = 64;
  localparam int unsigned QUANT_SHIFT     = $clog2(QUANT_STEP);
  localparam int unsigned QUANT_HALF      = QUANT_STEP / 2;

  localparam int unsigned REM_SPAN    = 2 * REMAINDER_BOUND + 1;
  localparam int unsigned TABLE_DEPTH = (2 * QUOTIENT_BOUND + 1) * REM_SPAN;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned INDEX_W  = 13;
  localparam int unsigned DIFF_W   = SAMPLE_W + 1;
  localparam int unsigned QMAG_W   = SAMPLE_W + 1 - QUANT_SHIFT;
  localparam int unsigned REM_W    = QUANT_SHIFT + 1;
  localparam int unsigned QOFF_W   = $clog2(2 * QUOTIENT_BOUND + 1);
  localparam int unsigned ROFF_W   = $clog2(REM_SPAN);
  localparam int unsigned ENTRY_W  = SYMBOL_W + 1;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [0:0] {
    REG_DELIMITER = 1'b0
  } reg_index_e;

  typedef enum logic [0:0] {
    FUNC_SAMPLE = 1'b0,
    FUNC_WRITE  = 1'b1
  } func_e;

  typedef struct packed {
    logic                valid;
    logic [SYMBOL_W-1:0] symbol;
  } entry_t;

endpackage

/* sv/delta_symbol_mapper.sv */
// ----------------------------------------------------------------------------
// delta_symbol_mapper
// Delta coder with escape: maps each sample difference to a table symbol,
// or to the delimiter plus a raw anchor sample when the pair has no entry.
//
//   channel  | dir | handshake              | word
//   ---------+-----+------------------------+---------------------------------
//   in       | in  | in_valid_i/in_ready_o  | func, sample, first, entry fields
//   out      | out | out_valid_o/out_ready_i| symbol, flags, anchor sample
//   cfg      | in  | APB psel/penable       | delimiter symbol at 0x0
//
// One word per cycle unless the output stalls; three register stages from input
// to output (input register, table read, output register). Table writes give
// no result; a record's first sample gives only its anchor. After reset the
// table is swept to invalid, one entry a cycle, with in_ready_o low. Stalls
// back up stage by stage; empty stages still fill.
// ----------------------------------------------------------------------------
module delta_symbol_mapper (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             func_i,
  input  logic [dsm_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic                             first_of_record_i,
  input  logic [dsm_pkg::INDEX_W-1:0]      entry_index_i,
  input  logic [dsm_pkg::SYMBOL_W-1:0]     entry_symbol_i,
  input  logic                             entry_valid_i,

  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dsm_pkg::SYMBOL_W-1:0]     symbol_o,
  output logic                             symbol_valid_o,
  output logic                             anchor_valid_o,
  output logic [dsm_pkg::SAMPLE_W-1:0]     anchor_sample_o,

  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dsm_pkg::PADDR_W-1:0]      paddr,
  input  logic [dsm_pkg::PDATA_W-1:0]      pwdata,
  output logic [dsm_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  import dsm_pkg::*;

  // configuration
  logic [SYMBOL_W-1:0] delim_q;
  logic                reg_sel;

  // clearing sweep
  logic               clr_busy_q;
  logic [INDEX_W-1:0] clr_cnt_q;

  // stage control
  logic en0, en1, en2, in_acc;

  // stage 1
  logic                     v1_q, func1_q, first1_q, evalid1_q;
  logic [SAMPLE_W-1:0]      sample1_q;
  logic signed [DIFF_W-1:0] diff1_q;
  logic [INDEX_W-1:0]       eidx1_q;
  logic [SYMBOL_W-1:0]      esym1_q;
  logic [SAMPLE_W-1:0]      prev_q;
  logic signed [DIFF_W-1:0] diff_d;

  // stage 1 quantiser
  logic                     neg;
  logic [DIFF_W-1:0]        mag_full;
  logic [SAMPLE_W-1:0]      mag;
  logic [DIFF_W-1:0]        qsum;
  logic [QMAG_W-1:0]        qmag;
  logic [QUANT_SHIFT-1:0]   low;
  logic signed [REM_W-1:0]  rm, rem, rb_s;
  logic                     in_range;
  logic [QOFF_W-1:0]        q_off;
  logic [ROFF_W-1:0]        r_off;
  logic [INDEX_W-1:0]       rd_idx;

  // stage 2
  logic                v2_q, first2_q, inr2_q;
  logic [SAMPLE_W-1:0] sample2_q;
  entry_t              rd_entry;
  logic                hit;

  // output register
  logic                ov_q, sv_q, av_q;
  logic [SYMBOL_W-1:0] sym_q, sym_d;
  logic [SAMPLE_W-1:0] as_q, as_d;
  logic                sv_d, av_d;

  // RAM port
  logic               ram_we, ram_re, tbl_wr;
  logic [INDEX_W-1:0] ram_waddr;
  entry_t             ram_wdata;

  // APB
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1 -: 1] == REG_DELIMITER);
  assign prdata  = reg_sel ? PDATA_W'(delim_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      delim_q <= pwdata[SYMBOL_W-1:0];
    end
  end

  // handshake
  assign en2        = !ov_q || out_ready_i;
  assign en1        = !v2_q || en2;
  assign en0        = !v1_q || en1;
  assign in_ready_o = en0 && !clr_busy_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == INDEX_W'(TABLE_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + INDEX_W'(1);
    end
  end

  // stage 1: difference against previous sample
  assign diff_d = $signed({1'b0, sample_i}) - $signed({1'b0, prev_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      prev_q <= '0;
    end else begin
      if (en0) begin
        v1_q <= in_acc;
      end
      if (in_acc && func_i == FUNC_SAMPLE) begin
        prev_q <= sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func1_q   <= func_i;
      first1_q  <= first_of_record_i;
      sample1_q <= sample_i;
      diff1_q   <= diff_d;
      eidx1_q   <= entry_index_i;
      esym1_q   <= entry_symbol_i;
      evalid1_q <= entry_valid_i;
    end
  end

  // quotient rounded half away from zero, remainder in -32..32
  always_comb begin
    neg      = diff1_q[DIFF_W-1];
    mag_full = neg ? DIFF_W'(-diff1_q) : DIFF_W'(diff1_q);
    mag      = mag_full[SAMPLE_W-1:0];
    qsum     = {1'b0, mag} + DIFF_W'(QUANT_HALF);
    qmag     = qsum[DIFF_W-1:QUANT_SHIFT];
    low      = mag[QUANT_SHIFT-1:0];
    rm       = $signed({low[QUANT_SHIFT-1], low});
    rem      = neg ? -rm : rm;
    rb_s     = REM_W'(REMAINDER_BOUND);
    in_range = (qmag <= QMAG_W'(QUOTIENT_BOUND)) && (rem >= -rb_s) && (rem <= rb_s);
    q_off    = neg ? QOFF_W'(QUOTIENT_BOUND) - qmag[QOFF_W-1:0]
                   : QOFF_W'(QUOTIENT_BOUND) + qmag[QOFF_W-1:0];
    r_off    = ROFF_W'(rem + rb_s);
    rd_idx   = INDEX_W'(q_off * INDEX_W'(REM_SPAN)) + INDEX_W'(r_off);
  end

  // table access
  assign tbl_wr = v1_q && func1_q == FUNC_WRITE && en1 &&
                  (eidx1_q < INDEX_W'(TABLE_DEPTH));
  assign ram_re = en1 && v1_q && func1_q == FUNC_SAMPLE;

  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we           = tbl_wr;
      ram_waddr        = eidx1_q;
      ram_wdata.valid  = evalid1_q;
      ram_wdata.symbol = evalid1_q ? esym1_q : '0;
    end
  end

  dsm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx),
    .rdata_o (rd_entry)
  );

  // stage 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en1) begin
      v2_q <= v1_q && func1_q == FUNC_SAMPLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      first2_q  <= first1_q;
      sample2_q <= sample1_q;
      inr2_q    <= in_range;
    end
  end

  always_comb begin
    hit = inr2_q && rd_entry.valid;
    if (first2_q) begin
      sym_d = '0;
      sv_d  = 1'b0;
      av_d  = 1'b1;
      as_d  = sample2_q;
    end else begin
      sym_d = hit ? rd_entry.symbol : delim_q;
      sv_d  = 1'b1;
      av_d  = !hit;
      as_d  = hit ? '0 : sample2_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en2) begin
      ov_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v2_q) begin
      sym_q <= sym_d;
      sv_q  <= sv_d;
      av_q  <= av_d;
      as_q  <= as_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign symbol_o        = sym_q;
  assign symbol_valid_o  = sv_q;
  assign anchor_valid_o  = av_q;
  assign anchor_sample_o = as_q;

endmodule

/* sv/dsm_ram.sv */
// ----------------------------------------------------------------------------
// dsm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* verif/dsm_symbol_checker.sv */
// ----------------------------------------------------------------------------
// dsm_symbol_checker
// Watches the input, output and configuration channels of the delta symbol
// mapper, predicts the symbol, flags and anchor for every sample word taken,
// and compares each result word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module dsm_symbol_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         func_i,
  input  logic [dsm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         first_of_record_i,
  input  logic [dsm_pkg::INDEX_W-1:0]  entry_index_i,
  input  logic [dsm_pkg::SYMBOL_W-1:0] entry_symbol_i,
  input  logic                         entry_valid_i,

  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [dsm_pkg::SYMBOL_W-1:0] symbol_i,
  input  logic                         symbol_valid_i,
  input  logic                         anchor_valid_i,
  input  logic [dsm_pkg::SAMPLE_W-1:0] anchor_sample_i,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dsm_pkg::PADDR_W-1:0]  paddr,
  input  logic [dsm_pkg::PDATA_W-1:0]  pwdata,
  input  logic                         pready,

  output int                           fail_count_o,
  output int                           pending_o,
  output int                           samples_o,
  output int                           starts_o,
  output int                           writes_o,
  output int                           hits_o,
  output int                           escapes_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import dsm_pkg::*;

  localparam logic [PADDR_W-1:0] DELIM_ADDR = PADDR_W'(4 * int'(REG_DELIMITER));

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                symbol_valid;
    logic                anchor_valid;
    logic [SAMPLE_W-1:0] anchor_sample;
  } mapped_t;

  entry_t              code_table [TABLE_DEPTH];
  logic [SAMPLE_W-1:0] last_sample;
  logic [SYMBOL_W-1:0] delimiter;
  mapped_t             pending_symbols [$];

  function automatic mapped_t map_sample(input logic [SAMPLE_W-1:0] s, input logic first);
    int      diff;
    int      mag;
    int      qmag;
    int      q;
    int      r;
    int      rmag;
    int      idx;
    mapped_t m;
    entry_t  e;
    m = '0;
    if (first) begin
      m.anchor_valid  = 1'b1;
      m.anchor_sample = s;
      return m;
    end
    diff = int'(s) - int'(last_sample);
    mag  = (diff < 0) ? -diff : diff;
    qmag = (mag + int'(QUANT_HALF)) / int'(QUANT_STEP);
    q    = (diff < 0) ? -qmag : qmag;
    r    = diff - q * int'(QUANT_STEP);
    rmag = (r < 0) ? -r : r;
    m.symbol       = delimiter;
    m.symbol_valid = 1'b1;
    if (qmag <= int'(QUOTIENT_BOUND) && rmag <= int'(REMAINDER_BOUND)) begin
      idx = (q + int'(QUOTIENT_BOUND)) * int'(REM_SPAN) + r + int'(REMAINDER_BOUND);
      e   = code_table[idx];
      if (e.valid) begin
        m.symbol = e.symbol;
        return m;
      end
    end
    m.anchor_valid  = 1'b1;
    m.anchor_sample = s;
    return m;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mapped_t m;
    if (!rst_ni) begin
      foreach (code_table[i]) code_table[i] = '0;
      last_sample  = '0;
      delimiter    = '0;
      pending_symbols.delete();
      fail_count_o = 0;
      pending_o    = 0;
      samples_o    = 0;
      starts_o     = 0;
      writes_o     = 0;
      hits_o       = 0;
      escapes_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == DELIM_ADDR) begin
        delimiter = pwdata[SYMBOL_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_symbols.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending (symbol %02h)",
                                    symbol_i));
        end else begin
          m = pending_symbols.pop_front();
          if (symbol_i !== m.symbol)
            report_mismatch($sformatf("symbol exp %02h got %02h", m.symbol, symbol_i));
          if (symbol_valid_i !== m.symbol_valid)
            report_mismatch($sformatf("symbol_valid exp %0b got %0b",
                                      m.symbol_valid, symbol_valid_i));
          if (anchor_valid_i !== m.anchor_valid)
            report_mismatch($sformatf("anchor_valid exp %0b got %0b",
                                      m.anchor_valid, anchor_valid_i));
          if (anchor_sample_i !== m.anchor_sample)
            report_mismatch($sformatf("anchor_sample exp %04h got %04h",
                                      m.anchor_sample, anchor_sample_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (func_i == FUNC_WRITE) begin
          writes_o++;
          if (entry_index_i < TABLE_DEPTH) begin
            code_table[entry_index_i] = entry_valid_i ? {1'b1, entry_symbol_i} : '0;
          end
        end else begin
          m = map_sample(sample_i, first_of_record_i);
          last_sample = sample_i;
          pending_symbols.push_back(m);
          samples_o++;
          if (!m.symbol_valid) starts_o++;
          else if (m.anchor_valid) escapes_o++;
          else hits_o++;
        end
      end
      pending_o = pending_symbols.size();
    end
  end

endmodule

/* verif/tb_delta_symbol_mapper.sv */
// ----------------------------------------------------------------------------
// tb_delta_symbol_mapper
// Drives the delta symbol mapper with a directed set of table loads and
// samples, then random well-formed delta sequences and noise across four
// flow-control phases, reprogramming the delimiter between phases.
// ----------------------------------------------------------------------------
module tb_delta_symbol_mapper;

  timeunit 1ns;
  timeprecision 1ps;

  import dsm_pkg::*;

  localparam int                 WORDS_PER_PHASE = 150;
  localparam int                 SETTLE_CYCLES   = 8;
  localparam int                 DRAIN_LIMIT     = 50000;
  localparam logic [PADDR_W-1:0] DELIM_ADDR      = PADDR_W'(4 * int'(REG_DELIMITER));
  localparam int                 PHASE_IDLE  [4] = '{0, 69, 0, 32};
  localparam int                 PHASE_STALL [4] = '{0, 0, 69, 32};
  localparam int                 PHASE_DELIM [4] = '{0, 255, 0, 128};

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                in_valid_i        = 1'b0;
  logic                in_ready_o;
  logic                func_i            = 1'b0;
  logic [SAMPLE_W-1:0] sample_i          = '0;
  logic                first_of_record_i = 1'b0;
  logic [INDEX_W-1:0]  entry_index_i     = '0;
  logic [SYMBOL_W-1:0] entry_symbol_i    = '0;
  logic                entry_valid_i     = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i       = 1'b0;
  logic [SYMBOL_W-1:0] symbol_o;
  logic                symbol_valid_o;
  logic                anchor_valid_o;
  logic [SAMPLE_W-1:0] anchor_sample_o;
  logic                psel              = 1'b0;
  logic                penable           = 1'b0;
  logic                pwrite            = 1'b0;
  logic [PADDR_W-1:0]  paddr             = '0;
  logic [PDATA_W-1:0]  pwdata            = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int fail_count;
  int pending;
  int n_samples;
  int n_starts;
  int n_writes;
  int n_hits;
  int n_escapes;

  int                  idle_pct  = 20;
  int                  stall_pct = 20;
  logic [SAMPLE_W-1:0] last_sent = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  delta_symbol_mapper dut (.*);

  dsm_symbol_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .func_i            (func_i),
    .sample_i          (sample_i),
    .first_of_record_i (first_of_record_i),
    .entry_index_i     (entry_index_i),
    .entry_symbol_i    (entry_symbol_i),
    .entry_valid_i     (entry_valid_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .symbol_i          (symbol_o),
    .symbol_valid_i    (symbol_valid_o),
    .anchor_valid_i    (anchor_valid_o),
    .anchor_sample_i   (anchor_sample_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .samples_o         (n_samples),
    .starts_o          (n_starts),
    .writes_o          (n_writes),
    .hits_o            (n_hits),
    .escapes_o         (n_escapes)
  );

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [INDEX_W-1:0] entry_at(input int q, input int r);
    return INDEX_W'((q + int'(QUOTIENT_BOUND)) * int'(REM_SPAN) + r + int'(REMAINDER_BOUND));
  endfunction

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic push_word(input func_e f, input logic [SAMPLE_W-1:0] s, input logic first,
                           input logic [INDEX_W-1:0] idx, input logic [SYMBOL_W-1:0] sym,
                           input logic ev);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i        <= 1'b1;
    func_i            <= f;
    sample_i          <= s;
    first_of_record_i <= first;
    entry_index_i     <= idx;
    entry_symbol_i    <= sym;
    entry_valid_i     <= ev;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_entry(input logic [INDEX_W-1:0] idx, input logic [SYMBOL_W-1:0] sym,
                             input logic ev);
    push_word(FUNC_WRITE, SAMPLE_W'($urandom), 1'($urandom), idx, sym, ev);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic first);
    push_word(FUNC_SAMPLE, s, first, INDEX_W'($urandom), SYMBOL_W'($urandom), 1'($urandom));
    last_sent = s;
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_word();
    int                  roll;
    int                  q;
    int                  r;
    logic [INDEX_W-1:0]  idx;
    roll = $urandom_range(99);
    if (roll < 15) begin
      if ($urandom_range(9) < 7) idx = entry_at(int'($urandom_range(6)) - 3,
                                                int'($urandom_range(62)) - 31);
      else idx = INDEX_W'($urandom);
      write_entry(idx, SYMBOL_W'($urandom), $urandom_range(9) < 8);
    end else if (roll < 23) begin
      send_sample(SAMPLE_W'($urandom), 1'b1);
    end else if (roll < 85) begin
      if ($urandom_range(9) < 8) q = int'($urandom_range(6)) - 3;
      else q = int'($urandom_range(100)) - 50;
      r = int'($urandom_range(64)) - 32;
      send_sample(last_sent + SAMPLE_W'(q * 64 + r), 1'b0);
    end else begin
      send_sample(SAMPLE_W'($urandom), 1'b0);
    end
  endtask

  initial begin
    #2_000_000;
    $display("delta_symbol_mapper verification failed");
    $finish;
  end

  initial begin
    int waited;
    waited = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    while (!in_ready_o) @(negedge clk_i);

    cfg_write(DELIM_ADDR, PDATA_W'(8'h3c));
    write_entry(entry_at(0, 0), 8'ha5, 1'b1);
    write_entry(entry_at(50, 31), 8'hff, 1'b1);
    write_entry(entry_at(-50, -31), 8'h00, 1'b1);
    write_entry(entry_at(1, -1), 8'h3c, 1'b1);
    write_entry(13'h1fff, 8'h77, 1'b1);
    write_entry(INDEX_W'(TABLE_DEPTH), 8'h11, 1'b1);
    write_entry(entry_at(0, 1), 8'hee, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'd63, 1'b0);
    send_sample(16'd64, 1'b0);
    send_sample(16'hffff, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'd3231, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'd32, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'd3232, 1'b0);
    send_sample(16'h5555, 1'b1);
    send_sample(16'haaaa, 1'b0);
    write_entry(entry_at(0, 0), 8'h5a, 1'b0);
    send_sample(16'haaaa, 1'b0);
    send_sample(16'haaaa, 1'b1);
    send_sample(16'haaaa, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      cfg_write(DELIM_ADDR, (ph == 2) ? PDATA_W'($urandom_range(255))
                                      : PDATA_W'(PHASE_DELIM[ph]));
      idle_pct  = PHASE_IDLE[ph];
      stall_pct = PHASE_STALL[ph];
      repeat (WORDS_PER_PHASE) random_word();
    end

    in_valid_i <= 1'b0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("run covered %0d sample words (%0d record starts) and %0d table writes",
             n_samples, n_starts, n_writes);
    $display("over four flow-control phases: %0d table hits, %0d escapes with anchor",
             n_hits, n_escapes);
    if (fail_count == 0 && pending == 0) begin
      $display("delta_symbol_mapper verification clean");
    end else begin
      $display("delta_symbol_mapper verification failed");
    end
    $finish;
  end

endmodule
